>>> rtl/core/scbcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbcd_pkg
// Shared types, codes and helper functions of the scale frame change detector.
// ----------------------------------------------------------------------------
package scbcd_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    // register indexes on the configuration port
    localparam logic [1:0] CFG_SIGNATURE = 2'd0;
    localparam logic [1:0] CFG_RISE_THR  = 2'd1;
    localparam logic [1:0] CFG_BAG_DROP  = 2'd2;

    localparam logic [7:0]  SIGNATURE_RESET = 8'd255;
    localparam logic [29:0] RISE_THR_RESET  = 30'd100000;
    localparam logic [39:0] BAG_DROP_RESET  = 40'd80000000;

    // result status codes
    localparam logic [2:0] STAT_CHANGE  = 3'd0;
    localparam logic [2:0] STAT_SAME    = 3'd1;
    localparam logic [2:0] STAT_DECR    = 3'd2;
    localparam logic [2:0] STAT_BAD_SIG = 3'd3;
    localparam logic [2:0] STAT_OVF     = 3'd4;

    // flag byte bit positions
    localparam int FLAG_OVF_BIT  = 7;
    localparam int FLAG_SIGN_BIT = 5;

    typedef struct packed {
        logic        sig_ok;
        logic        overflow;
        logic        negative;
        logic [2:0]  dp;
        logic [23:0] digits;
    } frame_t;

    // six packed digits, least significant nibble first; nibbles above nine
    // keep their binary value
    function automatic logic [20:0] bcd_value(input logic [23:0] d);
        logic [20:0] v;
        v = 21'(d[23:20]) * 21'd100000
          + 21'(d[19:16]) * 21'd10000
          + 21'(d[15:12]) * 21'd1000
          + 21'(d[11:8])  * 21'd100
          + 21'(d[7:4])   * 21'd10
          + 21'(d[3:0]);
        return v;
    endfunction

    // 10^(7-dp) * 16: micro-ounces per count
    function automatic logic [27:0] dp_scale(input logic [2:0] dp);
        logic [27:0] s;
        unique case (dp)
            3'd0:    s = 28'd160000000;
            3'd1:    s = 28'd16000000;
            3'd2:    s = 28'd1600000;
            3'd3:    s = 28'd160000;
            3'd4:    s = 28'd16000;
            3'd5:    s = 28'd1600;
            3'd6:    s = 28'd160;
            default: s = 28'd16;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/scale_bcd_frame_change_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_bcd_frame_change_detector
// Groups UART bytes into 6-byte scale frames and reports weight changes.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_ready  | rx_byte
//  result   | out_valid/ out_ready | status, weight_delta, new_weight
//  config   | cfg_we               | cfg_index, cfg_data
//
// one byte per cycle; the closing byte of a frame waits only while the
// two-entry frame queue is full. the back part steps a converted frame
// through multiply, sign and delta states to the finish state, and sends a
// rejected one straight to finish, where it waits while the result register
// is full. reset clears the byte counter, queue pointers, last digits, last
// weight and result valid, and loads the configuration registers' defaults.
// ----------------------------------------------------------------------------
module scale_bcd_frame_change_detector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic signed [49:0]  weight_delta,
    output logic signed [48:0]  new_weight,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [39:0]         cfg_data
);

    logic [7:0]          signature_reg;
    logic [29:0]         rise_thr_reg;
    logic [39:0]         bag_drop_reg;
    logic signed [40:0]  lower_lim_reg;

    scbcd_pkg::frame_t   push_frame;
    scbcd_pkg::frame_t   pop_frame;
    logic                push;
    logic                pop;
    logic                q_empty;
    logic                q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signature_reg <= scbcd_pkg::SIGNATURE_RESET;
            rise_thr_reg  <= scbcd_pkg::RISE_THR_RESET;
            bag_drop_reg  <= scbcd_pkg::BAG_DROP_RESET;
            lower_lim_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    scbcd_pkg::CFG_SIGNATURE: signature_reg <= cfg_data[7:0];
                    scbcd_pkg::CFG_RISE_THR:  rise_thr_reg  <= cfg_data[29:0];
                    scbcd_pkg::CFG_BAG_DROP:  bag_drop_reg  <= cfg_data;
                    default:                  ;
                endcase
            end
            // delta <= thr - drop marks a bag change
            lower_lim_reg <= $signed({11'b0, rise_thr_reg}) - $signed({1'b0, bag_drop_reg});
        end
    end

    scbcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .signature (signature_reg),
        .q_full    (q_full),
        .push      (push),
        .frame     (push_frame)
    );

    scbcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_frame (push_frame),
        .pop      (pop),
        .rd_frame (pop_frame),
        .empty    (q_empty),
        .full     (q_full)
    );

    scbcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_frame      (pop_frame),
        .q_empty      (q_empty),
        .q_pop        (pop),
        .rise_thr     (rise_thr_reg),
        .lower_lim    (lower_lim_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .weight_delta (weight_delta),
        .new_weight   (new_weight)
    );

endmodule

>>> rtl/core/scbcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbcd_front
// Byte counter and frame store; pushes one frame record per six bytes.
// ----------------------------------------------------------------------------
module scbcd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          signature,
    input  logic                q_full,
    output logic                push,
    output scbcd_pkg::frame_t   frame
);

    logic [scbcd_pkg::POS_W-1:0] pos_reg;
    logic [7:0]                  store_reg [scbcd_pkg::STORE_DEPTH];
    logic                        accept;
    logic                        last_byte;

    assign last_byte = (pos_reg == scbcd_pkg::LAST_POS);
    // only the closing byte needs room in the queue
    assign in_ready  = !last_byte || !q_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= last_byte ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !last_byte)
        begin
            store_reg[pos_reg] <= rx_byte;
        end
    end

    always_comb
    begin
        frame.sig_ok   = (store_reg[0] == signature);
        frame.overflow = store_reg[1][scbcd_pkg::FLAG_OVF_BIT];
        frame.negative = store_reg[1][scbcd_pkg::FLAG_SIGN_BIT];
        frame.dp       = store_reg[1][2:0];
        frame.digits   = {store_reg[4], store_reg[3], store_reg[2]};
    end

endmodule

>>> rtl/core/scbcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbcd_queue
// Two-entry frame queue between the front and back parts.
// ----------------------------------------------------------------------------
module scbcd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scbcd_pkg::frame_t   wr_frame,
    input  logic                pop,
    output scbcd_pkg::frame_t   rd_frame,
    output logic                empty,
    output logic                full
);

    scbcd_pkg::frame_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push;
    logic              do_pop;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_frame = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_frame;
        end
    end

endmodule

>>> rtl/core/scbcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbcd_back
// Frame checks, weight conversion, change decision and result register.
// ----------------------------------------------------------------------------
module scbcd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scbcd_pkg::frame_t    q_frame,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic [29:0]          rise_thr,
    input  logic signed [40:0]   lower_lim,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic signed [49:0]   weight_delta,
    output logic signed [48:0]   new_weight
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_SGN  = 5'b00100,
        ST_DLT  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t              state_reg;
    logic [23:0]         last_digits_reg;
    logic signed [48:0]  last_weight_reg;
    logic                err_reg;
    logic [2:0]          err_code_reg;
    logic [20:0]         bcd_reg;
    logic [27:0]         scale_reg;
    logic                neg_reg;
    logic [47:0]         prod_reg;
    logic signed [48:0]  weight_reg;
    logic signed [49:0]  delta_reg;
    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic signed [49:0]  delta_out_reg;
    logic signed [48:0]  weight_out_reg;

    logic [47:0]         prod_full;
    logic signed [48:0]  prod_signed;
    logic signed [50:0]  delta_ext;
    logic signed [50:0]  thr_ext;
    logic signed [50:0]  lim_ext;
    logic                changed;
    logic                slot_free;
    logic                finish;

    assign q_pop        = (state_reg == ST_IDLE) && !q_empty;
    // fifteen in every nibble at the coarsest scale still fits in 48 bits
    assign prod_full    = 48'(bcd_reg) * 48'(scale_reg);
    assign prod_signed  = $signed({1'b0, prod_reg});
    assign delta_ext    = {delta_reg[49], delta_reg};
    assign thr_ext      = $signed({21'b0, rise_thr});
    assign lim_ext      = {{10{lower_lim[40]}}, lower_lim};
    // rise above threshold, or drop past the bag-change limit
    assign changed      = (delta_ext > thr_ext) || (delta_ext <= lim_ext);
    assign slot_free    = !out_valid_reg || out_ready;
    assign finish       = (state_reg == ST_FIN) && slot_free;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign weight_delta = delta_out_reg;
    assign new_weight   = weight_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_digits_reg <= '0;
            last_weight_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (!q_frame.sig_ok || (q_frame.digits == last_digits_reg)
                            || q_frame.overflow)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            last_digits_reg <= q_frame.digits;
                            state_reg       <= ST_MUL;
                        end
                    end
                end
                ST_MUL:  state_reg <= ST_SGN;
                ST_SGN:  state_reg <= ST_DLT;
                ST_DLT:  state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                        if (!err_reg && changed)
                        begin
                            last_weight_reg <= weight_reg;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bcd_reg   <= scbcd_pkg::bcd_value(q_frame.digits);
            scale_reg <= scbcd_pkg::dp_scale(q_frame.dp);
            neg_reg   <= q_frame.negative;
            err_reg   <= 1'b1;
            // checks in order: signature, repeated digits, overflow
            if (!q_frame.sig_ok)
            begin
                err_code_reg <= scbcd_pkg::STAT_BAD_SIG;
            end
            else if (q_frame.digits == last_digits_reg)
            begin
                err_code_reg <= scbcd_pkg::STAT_SAME;
            end
            else if (q_frame.overflow)
            begin
                err_code_reg <= scbcd_pkg::STAT_OVF;
            end
            else
            begin
                err_reg      <= 1'b0;
                err_code_reg <= scbcd_pkg::STAT_CHANGE;
            end
        end

        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_full;
        end
        if (state_reg == ST_SGN)
        begin
            weight_reg <= neg_reg ? -prod_signed : prod_signed;
        end
        if (state_reg == ST_DLT)
        begin
            delta_reg <= {weight_reg[48], weight_reg}
                       - {last_weight_reg[48], last_weight_reg};
        end

        if (finish)
        begin
            if (err_reg)
            begin
                status_reg     <= err_code_reg;
                delta_out_reg  <= '0;
                weight_out_reg <= '0;
            end
            else if (changed)
            begin
                status_reg     <= scbcd_pkg::STAT_CHANGE;
                delta_out_reg  <= delta_reg;
                weight_out_reg <= weight_reg;
            end
            else
            begin
                status_reg     <= scbcd_pkg::STAT_DECR;
                delta_out_reg  <= '0;
                weight_out_reg <= weight_reg;
            end
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame-level check of the scale frame change detector: a directed frame table
// followed by mostly well-formed random frames under several register
// settings, with random idling on both channels and one long output stall.
// Results are checked against an in-bench decoder or typed table rows.
// ----------------------------------------------------------------------------
module tb;

    localparam int         CYCLE_LIMIT = 300000;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [49:0] delta;
        logic signed [48:0] weight;
    } scale_result_t;

    typedef struct packed {
        logic [47:0]        frame;
        logic               typed;
        logic [2:0]         status;
        logic signed [49:0] delta;
        logic signed [48:0] weight;
    } frame_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic signed [49:0] weight_delta;
    logic signed [48:0] new_weight;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [39:0]        cfg_data;

    // decoder state
    logic [7:0]  sig_q;
    logic [29:0] thr_q;
    logic [39:0] drop_q;
    logic [2:0]  pos_q;
    logic [7:0]  frame_bytes [scbcd_pkg::FRAME_BYTES-1];
    logic [23:0] last_digits_q;
    logic [7:0]  last_flags_q;
    longint      last_weight_q;

    scale_result_t pending_readings [$];
    scale_result_t typed_result;
    bit            typed_pending;
    int            mismatch_count;
    int            send_idle;
    int            recv_idle;
    bit            hold_req;
    int            cycle_count;
    frame_row_t    frame_table [7];

    scale_bcd_frame_change_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .weight_delta (weight_delta),
        .new_weight   (new_weight),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // takes one byte; returns 1 when it closes a frame
    function automatic bit decode_scale_byte(input logic [7:0] b, output scale_result_t r);
        logic [23:0] digits;
        logic [7:0]  flags;
        longint      weight;
        longint      delta;
        longint      thr;
        longint      drop;
        int          shifts;
        r = '0;
        if (pos_q < 3'(scbcd_pkg::FRAME_BYTES - 1))
        begin
            frame_bytes[pos_q] = b;
            pos_q = pos_q + 3'd1;
            return 1'b0;
        end
        pos_q = '0;
        if (frame_bytes[0] != sig_q)
        begin
            r.status = scbcd_pkg::STAT_BAD_SIG;
            return 1'b1;
        end
        digits = {frame_bytes[4], frame_bytes[3], frame_bytes[2]};
        if (digits == last_digits_q)
        begin
            r.status = scbcd_pkg::STAT_SAME;
            return 1'b1;
        end
        flags = frame_bytes[1];
        if (flags[scbcd_pkg::FLAG_OVF_BIT])
        begin
            r.status = scbcd_pkg::STAT_OVF;
            return 1'b1;
        end
        last_digits_q = digits;
        last_flags_q  = flags;
        // nibbles above nine keep their binary value
        weight = 0;
        for (int k = 5; k >= 0; k--)
            weight = weight * 10 + longint'(digits[4*k +: 4]);
        weight = weight * 16;
        shifts = 7 - int'(flags[2:0]);
        for (int k = 0; k < shifts; k++)
            weight = weight * 10;
        if (flags[scbcd_pkg::FLAG_SIGN_BIT])
            weight = -weight;
        delta = weight - last_weight_q;
        thr   = longint'({34'd0, thr_q});
        drop  = longint'({24'd0, drop_q});
        r.weight = weight[48:0];
        if (delta > thr || delta - thr <= -drop)
        begin
            last_weight_q = weight;
            r.status = scbcd_pkg::STAT_CHANGE;
            r.delta  = delta[49:0];
        end
        else
        begin
            r.status = scbcd_pkg::STAT_DECR;
        end
        return 1'b1;
    endfunction

    function automatic logic [47:0] make_scale_frame();
        int          kind;
        logic [7:0]  head;
        logic [7:0]  flags;
        logic [23:0] digits;
        kind = $urandom_range(0, 99);
        // broken frame: random bytes throughout
        if (kind < 5)
            return {$urandom, 16'($urandom)};
        head  = ($urandom_range(0, 99) < 90) ? sig_q : 8'($urandom);
        flags = 8'($urandom);
        flags[scbcd_pkg::FLAG_OVF_BIT] = ($urandom_range(0, 9) == 0);
        if (kind < 25)
        begin
            digits = last_digits_q;
        end
        else if (kind < 55)
        begin
            // small step from the last reading, same scale and sign
            digits = last_digits_q;
            digits[3:0] = 4'($urandom_range(0, 9));
            flags[2:0] = last_flags_q[2:0];
            flags[scbcd_pkg::FLAG_SIGN_BIT] = last_flags_q[scbcd_pkg::FLAG_SIGN_BIT];
        end
        else if (kind < 85)
        begin
            for (int k = 0; k < 6; k++)
                digits[4*k +: 4] = 4'($urandom_range(0, 9));
        end
        else
        begin
            digits = 24'($urandom);
        end
        return {head, flags, digits[7:0], digits[15:8], digits[23:16], 8'($urandom)};
    endfunction

    task automatic push_rx_byte(input logic [7:0] b);
        scale_result_t r;
        if (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (decode_scale_byte(b, r))
        begin
            if (typed_pending)
            begin
                r = typed_result;
                typed_pending = 1'b0;
            end
            pending_readings.push_back(r);
        end
    endtask

    task automatic send_frame(input logic [47:0] f);
        for (int i = 0; i < scbcd_pkg::FRAME_BYTES; i++)
            push_rx_byte(f[47 - 8*i -: 8]);
    endtask

    task automatic send_random_frames(input int n);
        for (int i = 0; i < n; i++)
            send_frame(make_scale_frame());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [39:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            scbcd_pkg::CFG_SIGNATURE: sig_q  = data[7:0];
            scbcd_pkg::CFG_RISE_THR:  thr_q  = data[29:0];
            scbcd_pkg::CFG_BAG_DROP:  drop_q = data;
            default:                  ;
        endcase
    endtask

    // drain all results, then let the back end settle before touching registers
    task automatic quiesce();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // result side: check each transaction, then pick the next ready level
    initial
    begin : result_side
        int hold_left;
        bit hold_done;
        scale_result_t want;
        hold_left      = 0;
        hold_done      = 1'b0;
        mismatch_count = 0;
        out_ready      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    $display("%0t: result with none expected: status %0d delta %0d weight %0d",
                             $time, status, weight_delta, new_weight);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                        mismatch_count++;
                    end
                    if (weight_delta !== want.delta)
                    begin
                        $display("%0t: weight_delta expected %0d got %0d",
                                 $time, want.delta, weight_delta);
                        mismatch_count++;
                    end
                    if (new_weight !== want.weight)
                    begin
                        $display("%0t: new_weight expected %0d got %0d",
                                 $time, want.weight, new_weight);
                        mismatch_count++;
                    end
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL scale_bcd_frame_change_detector");
        $finish;
    end

    initial
    begin : stimulus
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rx_byte        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        typed_pending  = 1'b0;
        hold_req       = 1'b0;
        send_idle      = 14;
        recv_idle      = 83;
        sig_q          = scbcd_pkg::SIGNATURE_RESET;
        thr_q          = scbcd_pkg::RISE_THR_RESET;
        drop_q         = scbcd_pkg::BAG_DROP_RESET;
        pos_q          = '0;
        last_digits_q  = '0;
        last_flags_q   = '0;
        last_weight_q  = 0;
        for (int i = 0; i < scbcd_pkg::FRAME_BYTES - 1; i++)
            frame_bytes[i] = '0;

        frame_table = '{
            // all-zero digits right after reset repeat the cleared last digits
            '{48'hFF00_0000_0000, 1'b1, scbcd_pkg::STAT_SAME,    50'sd0, 49'sd0},
            '{48'hFF80_1234_56FF, 1'b1, scbcd_pkg::STAT_OVF,     50'sd0, 49'sd0},
            '{48'hFF00_0100_0000, 1'b1, scbcd_pkg::STAT_CHANGE,
              50'sd160000000, 49'sd160000000},
            // overflow that repeats the stored digits is reported as same
            '{48'hFF80_0100_0000, 1'b1, scbcd_pkg::STAT_SAME,    50'sd0, 49'sd0},
            '{48'h0000_0000_0000, 1'b1, scbcd_pkg::STAT_BAD_SIG, 50'sd0, 49'sd0},
            // negative, finest scale, every nibble at fifteen: large drop
            '{48'hFF27_FFFF_FF5A, 1'b0, scbcd_pkg::STAT_CHANGE,  50'sd0, 49'sd0},
            // one count up from there: too small to count
            '{48'hFF27_FEFF_FFA5, 1'b0, scbcd_pkg::STAT_CHANGE,  50'sd0, 49'sd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (frame_table[i])
        begin
            typed_pending = frame_table[i].typed;
            typed_result  = {frame_table[i].status, frame_table[i].delta,
                             frame_table[i].weight};
            send_frame(frame_table[i].frame);
        end

        // zero threshold and zero drop: every real change is taken
        quiesce();
        write_reg(scbcd_pkg::CFG_SIGNATURE, 40'h00_0000_00A5);
        write_reg(scbcd_pkg::CFG_RISE_THR, 40'd0);
        write_reg(scbcd_pkg::CFG_BAG_DROP, 40'd0);
        cfg_we <= 1'b0;
        send_frame(48'hA500_FFFF_FF00);
        send_frame(48'hA520_FFFF_FF00);
        send_random_frames(30);

        // widest threshold and drop
        quiesce();
        send_idle = 83;
        recv_idle = 14;
        write_reg(scbcd_pkg::CFG_SIGNATURE, 40'd0);
        write_reg(scbcd_pkg::CFG_RISE_THR, 40'h00_3FFF_FFFF);
        write_reg(scbcd_pkg::CFG_BAG_DROP, 40'hFF_FFFF_FFFF);
        cfg_we <= 1'b0;
        send_random_frames(30);

        // random settings; the spare index must be ignored
        quiesce();
        write_reg(CFG_SPARE, {8'($urandom), $urandom});
        write_reg(scbcd_pkg::CFG_SIGNATURE, 40'($urandom_range(0, 255)));
        write_reg(scbcd_pkg::CFG_RISE_THR, 40'($urandom_range(0, 1000000000)));
        write_reg(scbcd_pkg::CFG_BAG_DROP, {8'($urandom), $urandom});
        cfg_we <= 1'b0;
        send_random_frames(35);

        // back to reset values, full rate, with a long output stall
        quiesce();
        send_idle = 0;
        recv_idle = 0;
        write_reg(scbcd_pkg::CFG_SIGNATURE, 40'(scbcd_pkg::SIGNATURE_RESET));
        write_reg(scbcd_pkg::CFG_RISE_THR, 40'(scbcd_pkg::RISE_THR_RESET));
        write_reg(scbcd_pkg::CFG_BAG_DROP, scbcd_pkg::BAG_DROP_RESET);
        cfg_we <= 1'b0;
        hold_req = 1'b1;
        send_random_frames(35);

        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS scale_bcd_frame_change_detector");
        else
            $display("FAIL scale_bcd_frame_change_detector");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/scbcd_pkg.sv
rtl/core/scbcd_front.sv
rtl/core/scbcd_queue.sv
rtl/core/scbcd_back.sv
rtl/core/scale_bcd_frame_change_detector.sv
sim/tb.sv
